### hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared sizes, codes and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MEM_BYTES       = 1048576;
  localparam int MIN_BLOCK_BYTES = 128;
  localparam int OWNER_BITS      = 16;

  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 32;
  localparam int OWNER_W = 16;

  localparam int MEM_LOG2    = $clog2(MEM_BYTES);
  localparam int MIN_LOG2    = $clog2(MIN_BLOCK_BYTES);
  localparam int TREE_LEVELS = MEM_LOG2 - MIN_LOG2;
  localparam int SLOTS       = 1 << TREE_LEVELS;
  localparam int SLOT_W      = TREE_LEVELS;
  localparam int NODE_W      = TREE_LEVELS + 1;
  localparam int LVL_W       = $clog2(TREE_LEVELS + 2);
  localparam int USED_W      = $clog2(MEM_BYTES + 1);
  localparam int OWN_ST_W    = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  typedef enum logic [3:0] {
    OP_IDLE, OP_CLEAR, OP_LOAD, OP_DECODE, OP_RESULT_BAD, OP_RESULT_MISS,
    OP_DOWN_READ, OP_DOWN_STEP, OP_ALLOC_MARK, OP_SLOT_READ, OP_FREE_MARK,
    OP_UP_READ, OP_UP_WRITE, OP_ROOT_WRITE, OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    logic cmd_free;
    logic size_bad;
    logic no_room;
    logic at_target;
    logic at_root;
    logic addr_bad;
    logic slot_hit;
    logic clear_last;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic                 used_flag;
    logic [LVL_W-1:0]     level;
    logic [OWN_ST_W-1:0]  owner;
  } slot_ent_t;

  // number of bits needed to hold v (zero for zero)
  function automatic logic [5:0] bit_length(input logic [31:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) r = 6'(i + 1);
    end
    return r;
  endfunction

endpackage

### hw/rtl/bba_if.sv
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] request_size;
  logic [15:0] owner_id;
  logic [47:0] block_address;

  modport source (output valid, cmd, request_size, owner_id, block_address, input ready);
  modport sink   (input valid, cmd, request_size, owner_id, block_address, output ready);
endinterface

interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] result_address;
  logic [20:0] used_bytes;
  logic [20:0] free_bytes;

  modport source (output valid, status, result_address, used_bytes, free_bytes, input ready);
  modport sink   (input valid, status, result_address, used_bytes, free_bytes, output ready);
endinterface

### hw/rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a power-of-two region with owner checking on free.
// ----------------------------------------------------------------------------
//   channel  dir  handshake      word
//   req      in   valid/ready    cmd, request_size, owner_id, block_address
//   rsp      out  valid/ready    status, result_address, used_bytes, free_bytes
//   cfg      in   cfg_write      cfg_data -> mem_base
//
// One request is in flight at a time. An allocate walks down the tree one
// level at a time (a read, then a step) and climbs back up, reading and
// writing each parent word of the tree memory; a free reads the slot table
// and climbs from the freed block's level, and a rejected request is
// published straight after its checks (a free also after the slot table).
// After reset the tree and slot table are swept, one entry a cycle, over all
// 8192 entries before the first request is taken.
// A finished word waits in the output register; the next request is taken
// meanwhile and only its own result holds until rsp drains.
// ----------------------------------------------------------------------------
module buddy_block_allocator import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [ADDR_W-1:0] cfg_data,
  bba_req_if.sink           req,
  bba_rsp_if.source         rsp
);

  dp_op_t   op;
  dp_stat_t stat;

  // sequence the tree walk
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .op        (op)
  );

  // hold tree, slot table, counters and the result word
  bba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .stat        (stat),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .req_cmd     (req.cmd),
    .req_size    (req.request_size),
    .req_owner   (req.owner_id),
    .req_addr    (req.block_address),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_address (rsp.result_address),
    .rsp_used    (rsp.used_bytes),
    .rsp_free    (rsp.free_bytes)
  );

endmodule

### hw/rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: walks the buddy tree down and up by issuing datapath operations.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_CHECK, S_DOWN_STEP, S_DESCEND,
    S_SLOT_RD, S_SLOT_CHK, S_CLIMB, S_UP_WR, S_FIN
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_IDLE;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op         = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        op         = OP_DECODE;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.cmd_free) begin
          if (stat.addr_bad) begin
            op         = OP_RESULT_MISS;
            state_next = S_FIN;
          end else begin
            state_next = S_SLOT_RD;
          end
        end else if (stat.size_bad) begin
          op         = OP_RESULT_BAD;
          state_next = S_FIN;
        end else if (stat.no_room) begin
          op         = OP_RESULT_MISS;
          state_next = S_FIN;
        end else if (stat.at_target) begin
          op         = OP_ALLOC_MARK;
          state_next = S_CLIMB;
        end else begin
          op         = OP_DOWN_READ;
          state_next = S_DOWN_STEP;
        end
      end
      S_DOWN_STEP: begin
        op         = OP_DOWN_STEP;
        state_next = S_DESCEND;
      end
      S_DESCEND: begin
        if (stat.at_target) begin
          op         = OP_ALLOC_MARK;
          state_next = S_CLIMB;
        end else begin
          op         = OP_DOWN_READ;
          state_next = S_DOWN_STEP;
        end
      end
      S_SLOT_RD: begin
        op         = OP_SLOT_READ;
        state_next = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        if (stat.slot_hit) begin
          op         = OP_FREE_MARK;
          state_next = S_CLIMB;
        end else begin
          op         = OP_RESULT_MISS;
          state_next = S_FIN;
        end
      end
      S_CLIMB: begin
        if (stat.at_root) begin
          op         = OP_ROOT_WRITE;
          state_next = S_FIN;
        end else begin
          op         = OP_UP_READ;
          state_next = S_UP_WR;
        end
      end
      S_UP_WR: begin
        op         = OP_UP_WRITE;
        state_next = S_CLIMB;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          op         = OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: tree memory of per-node free levels, slot table, counters and
// the response register.
// ----------------------------------------------------------------------------
module bba_dp import bba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dp_op_t              op,
  output dp_stat_t            stat,
  input  logic                cfg_write,
  input  logic [ADDR_W-1:0]   cfg_data,
  input  logic                req_cmd,
  input  logic [SIZE_W-1:0]   req_size,
  input  logic [OWNER_W-1:0]  req_owner,
  input  logic [ADDR_W-1:0]   req_addr,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [1:0]          rsp_status,
  output logic [ADDR_W-1:0]   rsp_address,
  output logic [USED_W-1:0]   rsp_used,
  output logic [USED_W-1:0]   rsp_free
);

  localparam int WORD_W = 2 * LVL_W;

  logic [ADDR_W-1:0]  mem_base;
  logic               r_cmd;
  logic [SIZE_W-1:0]  r_size;
  logic [OWNER_W-1:0] r_owner;
  logic [ADDR_W-1:0]  r_addr;
  logic [LVL_W-1:0]   want;
  logic               size_bad;
  logic               addr_bad;
  logic [NODE_W-1:0]  node;
  logic [LVL_W-1:0]   lvl;
  logic [SLOT_W-1:0]  slot;
  logic [LVL_W-1:0]   val;
  logic [LVL_W-1:0]   root_f;
  logic [USED_W-1:0]  used;
  logic [1:0]         status;
  logic [ADDR_W-1:0]  result_addr;
  logic [SLOT_W-1:0]  clr_cnt;
  logic               out_valid;

  // free level per node, stored as sibling pairs under the parent index
  logic [WORD_W-1:0]  tree_mem [SLOTS];
  logic [WORD_W-1:0]  tree_rdata;
  slot_ent_t          slot_mem [SLOTS];
  slot_ent_t          slot_rdata;

  logic               tree_we;
  logic [SLOT_W-1:0]  tree_raddr;
  logic [SLOT_W-1:0]  tree_waddr;
  logic [WORD_W-1:0]  tree_wdata;
  logic [LVL_W-1:0]   init_f;
  logic [WORD_W-1:0]  new_word;
  logic [LVL_W-1:0]   new_lo, new_hi, ent_f, parent_f;
  logic               go_left;
  logic               slot_we;
  slot_ent_t          slot_wdata;
  logic [5:0]         size_bits;
  logic [LVL_W-1:0]   want_calc;
  logic [ADDR_W:0]    addr_diff;
  logic               addr_bad_calc;
  logic [USED_W-1:0]  alloc_bytes, free_bytes_blk;

  // tree memory
  always_comb begin
    init_f     = LVL_W'(TREE_LEVELS + 1) - LVL_W'(bit_length(32'(clr_cnt)));
    new_word   = node[0] ? {val, tree_rdata[LVL_W-1:0]}
                         : {tree_rdata[WORD_W-1:LVL_W], val};
    new_lo     = new_word[LVL_W-1:0];
    new_hi     = new_word[WORD_W-1:LVL_W];
    ent_f      = lvl + LVL_W'(1);
    if (new_lo == ent_f && new_hi == ent_f) begin
      parent_f = lvl + LVL_W'(2);
    end else begin
      parent_f = (new_lo > new_hi) ? new_lo : new_hi;
    end
    go_left    = tree_rdata[LVL_W-1:0] > want;
    tree_raddr = (op == OP_UP_READ) ? node[NODE_W-1:1] : node[SLOT_W-1:0];
    tree_we    = (op == OP_CLEAR) || (op == OP_UP_WRITE);
    tree_waddr = (op == OP_CLEAR) ? clr_cnt : node[NODE_W-1:1];
    tree_wdata = (op == OP_CLEAR) ? {init_f, init_f} : new_word;
  end

  always_ff @(posedge clk) begin
    if (tree_we) tree_mem[tree_waddr] <= tree_wdata;
    tree_rdata <= tree_mem[tree_raddr];
  end

  // slot table
  always_comb begin
    slot_we    = 1'b0;
    slot_wdata = slot_rdata;
    case (op)
      OP_CLEAR: begin
        slot_we    = 1'b1;
        slot_wdata = '0;
      end
      OP_ALLOC_MARK: begin
        slot_we    = 1'b1;
        slot_wdata = '{used_flag: 1'b1, level: want, owner: r_owner[OWN_ST_W-1:0]};
      end
      OP_FREE_MARK: begin
        slot_we              = 1'b1;
        slot_wdata.used_flag = 1'b0;
      end
      default: begin
        slot_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[(op == OP_CLEAR) ? clr_cnt : slot] <= slot_wdata;
    slot_rdata <= slot_mem[slot];
  end

  // request decode
  always_comb begin
    size_bits      = bit_length(r_size - SIZE_W'(1));
    want_calc      = (size_bits > 6'(MIN_LOG2)) ? LVL_W'(size_bits - 6'(MIN_LOG2)) : '0;
    addr_diff      = {1'b0, r_addr} - {1'b0, mem_base};
    addr_bad_calc  = addr_diff[ADDR_W]
                  || (addr_diff[ADDR_W-1:0] >= ADDR_W'(MEM_BYTES))
                  || (addr_diff[MIN_LOG2-1:0] != '0);
    alloc_bytes    = USED_W'(MIN_BLOCK_BYTES) << want;
    free_bytes_blk = USED_W'(MIN_BLOCK_BYTES) << slot_rdata.level;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_base  <= '0;
      root_f    <= LVL_W'(TREE_LEVELS + 1);
      used      <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) mem_base <= cfg_data;
      if (op == OP_CLEAR) clr_cnt <= clr_cnt + SLOT_W'(1);
      if (op == OP_ROOT_WRITE) root_f <= val;
      if (op == OP_ALLOC_MARK) used <= used + alloc_bytes;
      if (op == OP_FREE_MARK) begin
        used <= (used > free_bytes_blk) ? used - free_bytes_blk : '0;
      end
      if (op == OP_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        r_cmd       <= req_cmd;
        r_size      <= req_size;
        r_owner     <= req_owner;
        r_addr      <= req_addr;
        node        <= NODE_W'(1);
        lvl         <= LVL_W'(TREE_LEVELS);
        slot        <= '0;
        status      <= STATUS_OK;
        result_addr <= '0;
      end
      OP_DECODE: begin
        want     <= want_calc;
        size_bad <= (r_size == '0) || (r_size > SIZE_W'(MEM_BYTES));
        addr_bad <= addr_bad_calc;
        if (r_cmd == CMD_FREE) slot <= addr_diff[MEM_LOG2-1:MIN_LOG2];
      end
      OP_RESULT_BAD:  status <= STATUS_BAD;
      OP_RESULT_MISS: status <= STATUS_MISS;
      OP_DOWN_STEP: begin
        lvl  <= lvl - LVL_W'(1);
        node <= {node[NODE_W-2:0], ~go_left};
        if (!go_left) slot <= slot | (SLOT_W'(1) << (lvl - LVL_W'(1)));
      end
      OP_ALLOC_MARK: begin
        val         <= '0;
        result_addr <= mem_base + (ADDR_W'(slot) << MIN_LOG2);
      end
      OP_FREE_MARK: begin
        lvl  <= slot_rdata.level;
        node <= (NODE_W'(1) << (LVL_W'(TREE_LEVELS) - slot_rdata.level))
              | NODE_W'(slot >> slot_rdata.level);
        val  <= slot_rdata.level + LVL_W'(1);
      end
      OP_UP_WRITE: begin
        val  <= parent_f;
        node <= node >> 1;
        lvl  <= lvl + LVL_W'(1);
      end
      OP_PUBLISH: begin
        rsp_status  <= status;
        rsp_address <= result_addr;
        rsp_used    <= used;
        rsp_free    <= USED_W'(MEM_BYTES) - used;
      end
      default: begin
      end
    endcase
  end

  assign rsp_valid = out_valid;

  always_comb begin
    stat.cmd_free   = r_cmd == CMD_FREE;
    stat.size_bad   = size_bad;
    stat.no_room    = root_f <= want;
    stat.at_target  = lvl == want;
    stat.at_root    = node == NODE_W'(1);
    stat.addr_bad   = addr_bad;
    stat.slot_hit   = slot_rdata.used_flag && (slot_rdata.owner == r_owner[OWN_ST_W-1:0]);
    stat.clear_last = &clr_cnt;
    stat.out_busy   = out_valid && !rsp_ready;
  end

  a_down_level: assert property (@(posedge clk) disable iff (rst)
    op == OP_DOWN_STEP |=> lvl == $past(lvl) - LVL_W'(1))
    else $error("descent did not drop one level");

  a_mark_level: assert property (@(posedge clk) disable iff (rst)
    op == OP_ALLOC_MARK |-> lvl == want)
    else $error("block marked away from its size level");

  a_root_write: assert property (@(posedge clk) disable iff (rst)
    op == OP_ROOT_WRITE |-> node == NODE_W'(1))
    else $error("root updated from a non-root node");

  a_publish: assert property (@(posedge clk) disable iff (rst)
    op == OP_PUBLISH |=> rsp_valid)
    else $error("published word not presented");

endmodule
